/* rtl/bde_pkg.sv */
// Shared types and constants for the bounded deque engine.
// Holds the action, status, cell operation and controller state codes.
// It has no dependencies and every other file in rtl imports it.
package bde_pkg;

    localparam int DEPTH_DEF = 32;
    localparam int DATA_W    = 32;

    typedef enum logic [2:0] {
        ACT_PUSH_FRONT = 3'd0,
        ACT_PUSH_BACK  = 3'd1,
        ACT_POP_FRONT  = 3'd2,
        ACT_POP_BACK   = 3'd3,
        ACT_DUMP_FWD   = 3'd4,
        ACT_DUMP_REV   = 3'd5
    } action_t;

    typedef enum logic [1:0] {
        STAT_DONE  = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2,
        STAT_ELEM  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_SHIFT_IN,
        CELL_APPEND,
        CELL_SHIFT_OUT,
        CELL_ROT_LEFT,
        CELL_ROT_RIGHT
    } cell_op_t;

    typedef enum logic {
        ST_IDLE,
        ST_DUMP
    } state_t;

    typedef struct packed {
        cell_op_t                  op;
        logic signed [DATA_W-1:0]  data;
    } cell_ctrl_t;

endpackage

/* rtl/bde_cell.sv */
// One storage cell of the deque chain: holds a single entry.
// Cell zero is the front; entries sit in order in cells below the count.
// Depends on bde_pkg for the cell operation codes.
module bde_cell
    import bde_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int INDEX = 0,
    localparam int CNT_W = $clog2(DEPTH + 1)
)
(
    input  logic                      clk,
    input  cell_ctrl_t                ctrl,
    input  logic [CNT_W-1:0]          count,
    input  logic signed [DATA_W-1:0]  left_val,
    input  logic signed [DATA_W-1:0]  right_val,
    input  logic signed [DATA_W-1:0]  head_val,
    input  logic signed [DATA_W-1:0]  tail_val,
    output logic signed [DATA_W-1:0]  value
);

    localparam logic [CNT_W-1:0] MY_POS    = CNT_W'(INDEX);
    localparam logic [CNT_W-1:0] MY_POS_P1 = CNT_W'(INDEX + 1);

    logic signed [DATA_W-1:0] value_reg;
    logic signed [DATA_W-1:0] value_next;

    always_comb
    begin
        value_next = value_reg;
        case (ctrl.op)
            CELL_HOLD:
            begin
                value_next = value_reg;
            end
            CELL_SHIFT_IN:
            begin
                value_next = (INDEX == 0) ? ctrl.data : left_val;
            end
            CELL_APPEND:
            begin
                if (count == MY_POS)
                begin
                    value_next = ctrl.data;
                end
            end
            CELL_SHIFT_OUT:
            begin
                value_next = right_val;
            end
            CELL_ROT_LEFT:
            begin
                // The last occupied cell wraps the front entry around.
                value_next = (count == MY_POS_P1) ? head_val : right_val;
            end
            CELL_ROT_RIGHT:
            begin
                value_next = (INDEX == 0) ? tail_val : left_val;
            end
            default:
            begin
                value_next = value_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

/* rtl/bounded_deque_engine.sv */
// Bounded double-ended queue of signed 32-bit values built as a chain of cells.
// Depends on bde_pkg and bde_cell.
//
// Usage:
//   Input channel (in_valid, in_stall, action, push_value) takes one action
//   word: push front, push back, pop front, pop back, dump forward or dump
//   reverse. Output channel (out_valid, out_stall, status, element_value,
//   last) returns result words; last marks the final word of an action.
//   Push and pop words: the result is registered in the cycle after
//   acceptance and, while the receiver does not stall, a new action is taken
//   in the next cycle, so a steady stream of pushes and pops runs at one word
//   per cycle. A dump of N entries holds the input until its last entry is
//   emitted and, while the receiver does not stall, emits one entry per cycle,
//   front cell or tail cell, while the whole chain rotates by one place; after
//   N steps the contents are back in place. An empty dump gives one empty word.
//   When the receiver stalls, the output register holds its word and the
//   input and the chain wait. Reset empties the queue at once; cell
//   contents are not cleared since cells past the count are never read.
module bounded_deque_engine
    import bde_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [2:0]                action,
    input  logic signed [DATA_W-1:0]  push_value,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [1:0]                status,
    output logic signed [DATA_W-1:0]  element_value,
    output logic                      last
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

    state_t                    state_reg, state_next;
    logic [CNT_W-1:0]          count_reg, count_next;
    logic [CNT_W-1:0]          remain_reg, remain_next;
    logic                      rev_reg, rev_next;
    logic                      out_valid_reg, out_valid_next;
    status_t                   status_reg, status_next;
    logic signed [DATA_W-1:0]  elem_reg, elem_next;
    logic                      last_reg, last_next;

    cell_ctrl_t                ctrl;
    logic signed [DATA_W-1:0]  cell_vals [DEPTH];
    logic signed [DATA_W-1:0]  tail_val;
    logic [IDX_W-1:0]          tail_idx;
    logic                      out_free;
    logic                      accept;
    logic                      is_full;
    logic                      is_empty;

    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg != ST_IDLE) || !out_free;
    assign accept   = in_valid && !in_stall;
    assign is_full  = (count_reg == FULL_COUNT);
    assign is_empty = (count_reg == '0);
    assign tail_idx = IDX_W'(count_reg - 1'b1);
    assign tail_val = cell_vals[tail_idx];

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_cell
            logic signed [DATA_W-1:0] left_v;
            logic signed [DATA_W-1:0] right_v;
            if (g == 0)
            begin : g_first
                assign left_v = push_value;
            end
            else
            begin : g_mid_l
                assign left_v = cell_vals[g-1];
            end
            if (g == DEPTH - 1)
            begin : g_end
                assign right_v = cell_vals[g];
            end
            else
            begin : g_mid_r
                assign right_v = cell_vals[g+1];
            end
            bde_cell #(
                .DEPTH (DEPTH),
                .INDEX (g)
            ) u_cell (
                .clk       (clk),
                .ctrl      (ctrl),
                .count     (count_reg),
                .left_val  (left_v),
                .right_val (right_v),
                .head_val  (cell_vals[0]),
                .tail_val  (tail_val),
                .value     (cell_vals[g])
            );
        end
    endgenerate

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        remain_next    = remain_reg;
        rev_next       = rev_reg;
        out_valid_next = out_valid_reg;
        status_next    = status_reg;
        elem_next      = elem_reg;
        last_next      = last_reg;
        ctrl.op        = CELL_HOLD;
        ctrl.data      = push_value;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (action)
                        ACT_PUSH_FRONT,
                        ACT_PUSH_BACK:
                        begin
                            out_valid_next = 1'b1;
                            elem_next      = '0;
                            last_next      = 1'b1;
                            if (is_full)
                            begin
                                status_next = STAT_FULL;
                            end
                            else
                            begin
                                status_next = STAT_DONE;
                                count_next  = count_reg + 1'b1;
                                ctrl.op     = (action == ACT_PUSH_FRONT) ?
                                              CELL_SHIFT_IN : CELL_APPEND;
                            end
                        end
                        ACT_POP_FRONT,
                        ACT_POP_BACK:
                        begin
                            out_valid_next = 1'b1;
                            elem_next      = '0;
                            last_next      = 1'b1;
                            if (is_empty)
                            begin
                                status_next = STAT_EMPTY;
                            end
                            else
                            begin
                                status_next = STAT_DONE;
                                count_next  = count_reg - 1'b1;
                                // Popping at the back only moves the count.
                                if (action == ACT_POP_FRONT)
                                begin
                                    ctrl.op = CELL_SHIFT_OUT;
                                end
                            end
                        end
                        ACT_DUMP_FWD,
                        ACT_DUMP_REV:
                        begin
                            if (is_empty)
                            begin
                                out_valid_next = 1'b1;
                                status_next    = STAT_EMPTY;
                                elem_next      = '0;
                                last_next      = 1'b1;
                            end
                            else
                            begin
                                state_next  = ST_DUMP;
                                remain_next = count_reg;
                                rev_next    = (action == ACT_DUMP_REV);
                            end
                        end
                        default:
                        begin
                            // Unused codes are taken and dropped.
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_DUMP:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    status_next    = STAT_ELEM;
                    elem_next      = rev_reg ? tail_val : cell_vals[0];
                    last_next      = (remain_reg == CNT_W'(1));
                    ctrl.op        = rev_reg ? CELL_ROT_RIGHT : CELL_ROT_LEFT;
                    remain_next    = remain_reg - 1'b1;
                    if (remain_reg == CNT_W'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            remain_reg    <= '0;
            rev_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            remain_reg    <= remain_next;
            rev_reg       <= rev_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        elem_reg   <= elem_next;
        last_reg   <= last_next;
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign element_value = elem_reg;
    assign last          = last_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_COUNT)
        else $error("entry count exceeds depth");

    a_dump_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DUMP) |-> (remain_reg != '0) && (remain_reg <= count_reg))
        else $error("dump counter out of range");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (action == ACT_PUSH_BACK || action == ACT_PUSH_FRONT) && !is_full)
        |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("push did not grow the queue");

    a_dump_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DUMP) |=> (count_reg == $past(count_reg)))
        else $error("count changed during dump");

    a_dump_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DUMP && out_free && remain_reg == CNT_W'(1))
        |=> (out_valid_reg && last_reg && state_reg == ST_IDLE))
        else $error("dump did not end with a last word");

endmodule
